/* sv/utf8d_pkg.sv */
package utf8d_pkg;

  // Fixed field widths and buffer depth.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned BUF_DEPTH = 4;

  // Replacement character for malformed input.
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Lead byte classes: prefix masks and patterns.
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

  // Payload masks.
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;  // store the accepted input item in the buffer
    logic emit;       // register one result and drop its bytes
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hold;   // head sequence is incomplete and the string goes on
    logic empty;  // no bytes left in the buffer
  } dp_status_t;

endpackage

/* sv/utf8d_ctrl.sv */
module utf8d_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  utf8d_pkg::dp_status_t status_i,
  output utf8d_pkg::dp_cmd_t    cmd_o
);
  import utf8d_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hold) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = status_i.empty ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/utf8d_datapath.sv */
module utf8d_datapath #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  utf8d_pkg::dp_cmd_t          cmd_i,
  output utf8d_pkg::dp_status_t       status_o,
  input  logic [7:0]                  byte_in_i,
  input  logic                        last_byte_i,
  output logic [20:0]                 code_point_o,
  output logic [OFFSET_WIDTH-1:0]     byte_offset_o,
  output logic                        end_of_string_o
);
  import utf8d_pkg::*;

  logic [BYTE_W-1:0]       buf_q [BUF_DEPTH];
  logic [BYTE_W-1:0]       buf_d [BUF_DEPTH];
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [OFFSET_WIDTH-1:0] base_q, base_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic                    last_q, last_d;
  logic [CP_W-1:0]         cp_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic                    eos_q;

  logic [BYTE_W-1:0]       lead;
  logic [1:0]              need;
  logic                    bad_lead;
  logic [CP_W-1:0]         value;
  logic                    cut;
  logic                    bad_cont;
  logic                    stop;
  logic                    bad_all;
  logic [CNT_W-1:0]        consume;
  logic [CP_W-1:0]         cp_next;
  logic                    eos_next;
  logic [OFFSET_WIDTH:0]   base_sum;
  logic [OFFSET_WIDTH-1:0] base_sat;
  logic [OFFSET_WIDTH:0]   pos_sum;
  logic [OFFSET_WIDTH-1:0] pos_sat;

  // Decode the sequence that starts at the head of the buffer.
  always_comb begin
    lead     = buf_q[0];
    need     = 2'd0;
    bad_lead = 1'b0;
    value    = {{(CP_W-7){1'b0}}, lead[6:0]};
    cut      = 1'b0;
    bad_cont = 1'b0;
    stop     = 1'b0;
    if (lead[7]) begin
      if ((lead & LEAD2_MASK) == LEAD2_PAT) begin
        need  = 2'd1;
        value = {{(CP_W-BYTE_W){1'b0}}, lead & LEAD2_BITS};
      end else if ((lead & LEAD3_MASK) == LEAD3_PAT) begin
        need  = 2'd2;
        value = {{(CP_W-BYTE_W){1'b0}}, lead & LEAD3_BITS};
      end else if ((lead & LEAD4_MASK) == LEAD4_PAT) begin
        need  = 2'd3;
        value = {{(CP_W-BYTE_W){1'b0}}, lead & LEAD4_BITS};
      end else begin
        bad_lead = 1'b1;
      end
    end
    // Walk the continuation bytes; the first cut-off or bad byte ends the walk.
    for (int k = 1; k < BUF_DEPTH; k++) begin
      if (!stop && (k <= int'(need))) begin
        if (CNT_W'(k) >= cnt_q) begin
          cut  = 1'b1;
          stop = 1'b1;
        end else if ((buf_q[k] & CONT_MASK) != CONT_PAT) begin
          bad_cont = 1'b1;
          stop     = 1'b1;
        end else begin
          value = {value[CP_W-7:0], buf_q[k][5:0]};
        end
      end
    end
    bad_all  = bad_lead || bad_cont || cut;
    consume  = bad_all ? CNT_W'(1) : (CNT_W'(need) + CNT_W'(1));
    cp_next  = bad_all ? REPLACEMENT_CP : value;
    eos_next = last_q && (consume == cnt_q);
  end

  // Saturating offset arithmetic.
  always_comb begin
    base_sum = {1'b0, base_q} + {{(OFFSET_WIDTH+1-CNT_W){1'b0}}, consume};
    base_sat = base_sum[OFFSET_WIDTH] ? '1 : base_sum[OFFSET_WIDTH-1:0];
    pos_sum  = {1'b0, pos_q} + {{OFFSET_WIDTH{1'b0}}, 1'b1};
    pos_sat  = pos_sum[OFFSET_WIDTH] ? '1 : pos_sum[OFFSET_WIDTH-1:0];
  end

  // Buffer, counters and position updates.
  always_comb begin
    logic [CNT_W-1:0] idx;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    base_d = base_q;
    pos_d  = pos_q;
    last_d = last_q;
    idx    = '0;
    if (cmd_i.load_byte) begin
      buf_d[cnt_q[1:0]] = byte_in_i;
      cnt_d             = cnt_q + CNT_W'(1);
      last_d            = last_byte_i;
      if (cnt_q == '0) begin
        base_d = pos_q;
      end
      pos_d = last_byte_i ? '0 : pos_sat;
    end else if (cmd_i.emit) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        idx = CNT_W'(i) + consume;
        if (idx < CNT_W'(BUF_DEPTH)) begin
          buf_d[i] = buf_q[idx[1:0]];
        end
      end
      cnt_d  = cnt_q - consume;
      base_d = base_sat;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      base_q <= '0;
      pos_q  <= '0;
      last_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      base_q <= base_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  // Held bytes and the output register carry no reset.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (cmd_i.emit) begin
      cp_q  <= cp_next;
      off_q <= base_q;
      eos_q <= eos_next;
    end
  end

  assign status_o.hold  = cut && !last_q;
  assign status_o.empty = (cnt_q == '0);

  assign code_point_o    = cp_q;
  assign byte_offset_o   = off_q;
  assign end_of_string_o = eos_q;

endmodule

/* sv/utf8_to_code_point_decoder_top.sv */
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   byte_in_i, last_byte_i
// out      output     out_valid_o/out_ready_i code_point_o, byte_offset_o, end_of_string_o
//
// An item passes an accept state, then a scan state for each result plus one
// for a held incomplete tail, and an output state for each result, which
// waits on out_ready_i. Results come from the single decoder that scans the
// byte buffer head.
// Reset clears the controller, the byte count and the offset counters.
// The input stays stalled while results of the current item are pending.
module utf8_to_code_point_decoder_top #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              byte_in_i,
  input  logic                    last_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [20:0]             code_point_o,
  output logic [OFFSET_WIDTH-1:0] byte_offset_o,
  output logic                    end_of_string_o
);
  import utf8d_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing of accept, scan and output.
  utf8d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Byte buffer, decoder and offset counters.
  utf8d_datapath #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .byte_in_i       (byte_in_i),
    .last_byte_i     (last_byte_i),
    .code_point_o    (code_point_o),
    .byte_offset_o   (byte_offset_o),
    .end_of_string_o (end_of_string_o)
  );

  // The block never accepts an item while a result is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // An accepted item is always scanned before the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice without a scan");

  // The final result of a string leaves the buffer empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_string_o) |=> in_ready_o)
    else $error("bytes left over after end of string");

  // Commands are never issued together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load_byte && cmd.emit))
    else $error("load and emit in the same cycle");

endmodule
